// File: design/wia_pkg.sv
// Types and constants shared by the integer ALU front and back parts.
// No dependencies.
package wia_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIVU = 3'd3;
    localparam logic [2:0] OP_REMU = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic        wide_mode;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } t_cmd;

    typedef struct packed {
        logic [63:0] result_value;
        logic        status;
    } t_result;

    typedef enum logic [2:0] {
        KD_ADD,
        KD_SUB,
        KD_MUL,
        KD_DIV,
        KD_REM,
        KD_ZERO,
        KD_TRAP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        wide;
        logic [63:0] a;
        logic [63:0] b;
    } t_issue;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } t_state;

endpackage

// File: design/wia_front.sv
// Front part: accepts requests, masks operands, classifies and queues them.
// Depends on wia_pkg.
module wia_front #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  wia_pkg::t_cmd i_cmd,
    output logic          o_vld,
    output wia_pkg::t_issue o_item,
    input  logic          i_pop
);
    import wia_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_issue           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    t_issue           n_item;
    logic             push;
    logic [63:0]      a_m, b_m;
    logic             bz;

    assign busy  = (r_cnt == CNT_W'(DEPTH));
    assign push  = start && !busy;
    assign o_vld = (r_cnt != '0);
    assign o_item = r_mem[r_rd];

    always_comb begin
        a_m = i_cmd.wide_mode ? i_cmd.operand_a : {32'd0, i_cmd.operand_a[31:0]};
        b_m = i_cmd.wide_mode ? i_cmd.operand_b : {32'd0, i_cmd.operand_b[31:0]};
        bz  = (b_m == 64'd0);
        n_item.wide = i_cmd.wide_mode;
        n_item.a    = a_m;
        n_item.b    = b_m;
        case (i_cmd.operation)
            OP_ADD:  n_item.kind = KD_ADD;
            OP_SUB:  n_item.kind = KD_SUB;
            OP_MUL:  n_item.kind = KD_MUL;
            OP_DIVU: n_item.kind = bz ? KD_TRAP : KD_DIV;
            OP_REMU: n_item.kind = bz ? KD_TRAP : KD_REM;
            default: n_item.kind = KD_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(i_pop);
        end
    end

endmodule

// File: design/wia_back.sv
// Back part: executes queued requests; split multiply, radix-2 divider.
// Depends on wia_pkg.
module wia_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  wia_pkg::t_issue  i_item,
    output logic             o_pop,
    output logic             o_strobe,
    output wia_pkg::t_result o_result
);
    import wia_pkg::*;

    t_state      r_state, n_state;
    t_kind       r_kind;
    logic        r_wide;
    logic [63:0] r_pll;
    logic [31:0] r_plh, r_phl;
    logic [63:0] r_q, r_rem, r_b;
    logic [5:0]  r_cnt;
    logic        r_out_vld, n_out_vld;
    t_result     r_out, n_out;
    logic [65:0] diff;
    logic [63:0] n_q, n_rem, sum, mul;

    assign o_pop    = (r_state == ST_IDLE) && i_vld;
    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_vld && i_item.kind == KD_MUL) n_state = ST_MUL;
                else if (i_vld && (i_item.kind == KD_DIV || i_item.kind == KD_REM))
                    n_state = ST_DIV;
            end
            ST_MUL:  n_state = ST_IDLE;
            ST_DIV:  if (r_cnt == 6'd0) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        diff  = {1'b0, r_rem, r_q[63]} - {2'b00, r_b};
        n_rem = diff[65] ? {r_rem[62:0], r_q[63]} : diff[63:0];
        n_q   = {r_q[62:0], ~diff[65]};
        mul   = r_pll + {r_plh + r_phl, 32'd0};
        sum   = 64'd0;
        n_out_vld = 1'b0;
        n_out.status = 1'b0;
        n_out.result_value = 64'd0;
        case (r_state)
            ST_IDLE: begin
                if (i_vld) begin
                    case (i_item.kind)
                        KD_ADD:  sum = i_item.a + i_item.b;
                        KD_SUB:  sum = i_item.a - i_item.b;
                        default: sum = 64'd0;
                    endcase
                    n_out_vld = !(i_item.kind == KD_MUL || i_item.kind == KD_DIV
                                  || i_item.kind == KD_REM);
                    n_out.status = (i_item.kind == KD_TRAP);
                    n_out.result_value = i_item.wide ? sum : {32'd0, sum[31:0]};
                end
            end
            ST_MUL: begin
                n_out_vld = 1'b1;
                n_out.result_value = r_wide ? mul : {32'd0, mul[31:0]};
            end
            ST_DIV: begin
                n_out_vld = (r_cnt == 6'd0);
                n_out.result_value = (r_kind == KD_DIV) ? n_q : n_rem;
            end
            default: n_out_vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_item.kind;
            r_wide <= i_item.wide;
            r_b    <= i_item.b;
            r_pll  <= i_item.a[31:0] * i_item.b[31:0];
            r_plh  <= 32'(i_item.a[31:0] * i_item.b[63:32]);
            r_phl  <= 32'(i_item.a[63:32] * i_item.b[31:0]);
            r_q    <= i_item.wide ? i_item.a : {i_item.a[31:0], 32'd0};
            r_rem  <= 64'd0;
            r_cnt  <= i_item.wide ? 6'd63 : 6'd31;
        end else if (r_state == ST_DIV) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 6'd1;
        end
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |=> r_out_vld) else $error("multiply lost its result");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == 6'd0) |=> (r_out_vld && r_state == ST_IDLE))
        else $error("divide did not finish");
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != 6'd0) |=> !r_out_vld)
        else $error("result during divide");

endmodule

// File: design/wasm_integer_alu.sv
// Top level of the integer ALU: front queue plus execution back part.
// Depends on wia_pkg, wia_front, wia_back.
//
// Usage: drive i_cmd and raise start; the request is taken on an edge where
// start is high and busy is low. busy rises only when the request queue
// (QUEUE_DEPTH entries) is full.
// Each request yields one result on o_result, marked by o_strobe for a single
// cycle; results come in request order and cannot be held off.
// Add, subtract, unused codes and divide-by-zero traps complete in the idle
// state of the back part; multiply registers 32x32 partial products, then
// their sum; 32-bit or 64-bit divide and remainder run in the shared
// restoring divider (one quotient bit per cycle).
// Throughput: one add or subtract per cycle while the back part is idle;
// a multiply or divide occupies it, during which the queue absorbs requests.
// Reset empties the queue and drops any operation in progress.
module wasm_integer_alu #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  wia_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output wia_pkg::t_result o_result
);
    import wia_pkg::*;

    logic   q_vld, q_pop;
    t_issue q_item;

    wia_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_vld(q_vld), .o_item(q_item), .i_pop(q_pop)
    );

    wia_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(q_vld), .i_item(q_item),
        .o_pop(q_pop), .o_strobe(o_strobe), .o_result(o_result)
    );

endmodule
